/* src/rmq_pkg.sv */
// Package: widths, constants and small helpers for the matrix to quaternion core.
package rmq_pkg;
  localparam int unsigned DATA_W = 16;
  localparam int unsigned FRAC_BITS_DEF = 14;
  localparam int unsigned FRAC_MIN = 8;
  localparam int unsigned FRAC_MAX = 30;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] SAT_MIN = -16'sh8000;
endpackage

/* src/rotation_matrix_to_quaternion_core.sv */
// Pipeline: stage 1, stage 2, RT_N root stages, the S stage, (FRAC_BITS+17) divide stages
// and an output register, with RT_N half the even-padded radicand width (17 by default).
// Throughput: one item per cycle, every cycle; the chain of per-bit stages sets the latency.
// Reset: rst (synchronous) clears all stage valid bits; in-flight items are dropped.
// The receiver cannot stall: done pulses one cycle with the result ports.
// busy is held low since every stage advances on every clock.
module rotation_matrix_to_quaternion_core #(
  parameter int unsigned FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [rmq_pkg::DATA_W-1:0] r00,
  input  logic signed [rmq_pkg::DATA_W-1:0] r01,
  input  logic signed [rmq_pkg::DATA_W-1:0] r02,
  input  logic signed [rmq_pkg::DATA_W-1:0] r10,
  input  logic signed [rmq_pkg::DATA_W-1:0] r11,
  input  logic signed [rmq_pkg::DATA_W-1:0] r12,
  input  logic signed [rmq_pkg::DATA_W-1:0] r20,
  input  logic signed [rmq_pkg::DATA_W-1:0] r21,
  input  logic signed [rmq_pkg::DATA_W-1:0] r22,
  output logic                              done,
  output logic signed [rmq_pkg::DATA_W-1:0] quat_w,
  output logic signed [rmq_pkg::DATA_W-1:0] quat_x,
  output logic signed [rmq_pkg::DATA_W-1:0] quat_y,
  output logic signed [rmq_pkg::DATA_W-1:0] quat_z,
  output logic                              degenerate
);
  import rmq_pkg::*;

  // root argument a <= ONE + 3*32768 < 2^(F+1) + 2^17; radicand a<<F
  localparam int unsigned A_W    = ((FRAC_BITS + 2) > 19) ? (FRAC_BITS + 2) : 19;
  localparam int unsigned RAD_W0 = A_W + FRAC_BITS;
  localparam int unsigned RAD_W  = RAD_W0 + (RAD_W0 % 2);
  localparam int unsigned RT_N   = RAD_W / 2;          // root bits = stages
  localparam int unsigned S_W    = RT_N + 1;
  localparam int unsigned N_W    = 17;                 // off-diagonal sum magnitude
  localparam int unsigned NUM_W  = N_W + FRAC_BITS;
  localparam int unsigned NQ     = 3;
  localparam logic [A_W-1:0] ONE_A = A_W'(1) << FRAC_BITS;

  assign busy = 1'b0;

  // ---------------- stage 1: trace, branch, root argument, numerators
  logic                       v1;
  branch_t                    br1;
  logic signed [A_W:0]        a1;
  logic signed [N_W:0]        n1 [NQ];

  logic signed [17:0] tr;
  branch_t            br_c;
  logic signed [A_W:0] a_c;
  logic signed [17:0] e00, e11, e22;
  assign e00 = 18'(r00);
  assign e11 = 18'(r11);
  assign e22 = 18'(r22);
  assign tr  = e00 + e11 + e22;

  always_comb begin
    if (tr > 0) begin
      br_c = BR_TRACE;
      a_c  = (A_W+1)'(tr);
    end else if (r00 > r11 && r00 > r22) begin
      br_c = BR_X;
      a_c  = (A_W+1)'(e00 - e11 - e22);
    end else if (r11 > r22) begin
      br_c = BR_Y;
      a_c  = (A_W+1)'(e11 - e00 - e22);
    end else begin
      br_c = BR_Z;
      a_c  = (A_W+1)'(e22 - e00 - e11);
    end
  end

  logic signed [N_W:0] d21m12, d02m20, d10m01, s01p10, s02p20, s12p21;
  assign d21m12 = (N_W+1)'(r21) - (N_W+1)'(r12);
  assign d02m20 = (N_W+1)'(r02) - (N_W+1)'(r20);
  assign d10m01 = (N_W+1)'(r10) - (N_W+1)'(r01);
  assign s01p10 = (N_W+1)'(r01) + (N_W+1)'(r10);
  assign s02p20 = (N_W+1)'(r02) + (N_W+1)'(r20);
  assign s12p21 = (N_W+1)'(r12) + (N_W+1)'(r21);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start & ~busy;
    end
    br1 <= br_c;
    a1  <= a_c;
    case (br_c)
      BR_TRACE: begin n1[0] <= d21m12; n1[1] <= d02m20; n1[2] <= d10m01; end
      BR_X:     begin n1[0] <= d21m12; n1[1] <= s01p10; n1[2] <= s02p20; end
      BR_Y:     begin n1[0] <= d02m20; n1[1] <= s01p10; n1[2] <= s12p21; end
      default:  begin n1[0] <= d10m01; n1[1] <= s02p20; n1[2] <= s12p21; end
    endcase
  end

  // ---------------- stage 2: add ONE, clamp negative
  logic               v2;
  branch_t            br2;
  logic [RAD_W-1:0]   rad2;
  logic signed [N_W:0] n2 [NQ];
  logic signed [A_W+1:0] a_sum;
  assign a_sum = (A_W+2)'(a1) + (A_W+2)'(signed'({1'b0, ONE_A}));

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    br2  <= br1;
    n2   <= n1;
    rad2 <= a_sum[A_W+1] ? '0 : (RAD_W'(a_sum[A_W-1:0]) << FRAC_BITS);
  end

  // ---------------- root pipeline: one root bit per stage (digit-by-digit)
  logic               rv  [RT_N+1];
  logic [RAD_W-1:0]   rrd [RT_N+1];
  logic [RT_N+1:0]    rrm [RT_N+1];
  logic [RT_N-1:0]    rq  [RT_N+1];
  branch_t            rb  [RT_N+1];
  logic signed [N_W:0] rn [RT_N+1][NQ];

  assign rv[0]  = v2;
  assign rrd[0] = rad2;
  assign rrm[0] = '0;
  assign rq[0]  = '0;
  assign rb[0]  = br2;
  assign rn[0]  = n2;

  for (genvar k = 0; k < RT_N; k++) begin : g_root
    logic [RT_N+1:0] trial;
    logic [RT_N+1:0] cur;
    logic [RT_N+1:0] dif;
    logic            ok;
    assign cur   = {rrm[k][RT_N-1:0], rrd[k][RAD_W-1 -: 2]};
    assign trial = {rq[k], 2'b01};
    assign ok    = cur >= trial;
    assign dif   = cur - trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        rv[k+1] <= 1'b0;
      end else begin
        rv[k+1] <= rv[k];
      end
      rrd[k+1] <= rrd[k] << 2;
      rrm[k+1] <= ok ? dif : cur;
      rq[k+1]  <= {rq[k][RT_N-2:0], ok};
      rb[k+1]  <= rb[k];
      rn[k+1]  <= rn[k];
    end
  end

  // ---------------- stage: S, numerator signs and magnitudes
  logic               v3;
  branch_t            br3;
  logic [S_W-1:0]     s3;
  logic [NUM_W-1:0]   nm3 [NQ];
  logic               ng3 [NQ];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= rv[RT_N];
    end
    br3 <= rb[RT_N];
    s3  <= {rq[RT_N], 1'b0};
    for (int q = 0; q < NQ; q++) begin
      ng3[q] <= rn[RT_N][q][N_W];
      nm3[q] <= NUM_W'(rn[RT_N][q][N_W] ? -rn[RT_N][q] : rn[RT_N][q]) << FRAC_BITS;
    end
  end

  // ---------------- three dividers in lockstep
  logic               dv  [NQ];
  logic [NUM_W-1:0]   dq  [NQ];
  logic               dng [NQ];
  logic [S_W+1:0]     dtag [NQ];

  for (genvar q = 0; q < NQ; q++) begin : g_div
    rmq_div #(.NUM_W(NUM_W), .DEN_W(S_W), .TAG_W(S_W + 2)) u_div (
      .clk      (clk),
      .rst      (rst),
      .in_valid (v3),
      .num_mag  (nm3[q]),
      .num_neg  (ng3[q]),
      .den      (s3),
      .in_tag   ({br3, s3}),
      .out_valid(dv[q]),
      .quot_mag (dq[q]),
      .quot_neg (dng[q]),
      .out_tag  (dtag[q])
    );
  end

  // ---------------- output stage: saturate and place
  function automatic logic signed [DATA_W-1:0] sat_q(logic [NUM_W-1:0] m, logic neg);
    logic signed [NUM_W:0] v;
    v = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    if (v > (NUM_W+1)'(SAT_MAX)) return SAT_MAX;
    if (v < (NUM_W+1)'(SAT_MIN)) return SAT_MIN;
    return v[DATA_W-1:0];
  endfunction

  branch_t            bro;
  logic [S_W-1:0]     so;
  logic [S_W-2:0]     diag_u;
  logic signed [DATA_W-1:0] diag, q0, q1, q2, one_sat;
  assign bro    = branch_t'(dtag[0][S_W+1:S_W]);
  assign so     = dtag[0][S_W-1:0];
  assign diag_u = (S_W-1)'(so >> 2);
  assign diag   = (diag_u > (S_W-1)'(SAT_MAX)) ? SAT_MAX : DATA_W'(diag_u);
  assign q0     = sat_q(dq[0], dng[0]);
  assign q1     = sat_q(dq[1], dng[1]);
  assign q2     = sat_q(dq[2], dng[2]);
  assign one_sat = (FRAC_BITS >= DATA_W - 1) ? SAT_MAX : DATA_W'(1 << FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[0];
    end
    if (so == '0) begin
      quat_w <= one_sat; quat_x <= '0; quat_y <= '0; quat_z <= '0;
      degenerate <= 1'b1;
    end else begin
      degenerate <= 1'b0;
      case (bro)
        BR_TRACE: begin quat_w <= diag; quat_x <= q0; quat_y <= q1; quat_z <= q2; end
        BR_X:     begin quat_w <= q0; quat_x <= diag; quat_y <= q1; quat_z <= q2; end
        BR_Y:     begin quat_w <= q0; quat_x <= q1; quat_y <= diag; quat_z <= q2; end
        default:  begin quat_w <= q0; quat_x <= q1; quat_y <= q2; quat_z <= diag; end
      endcase
    end
  end
endmodule

/* src/rmq_div.sv */
// Pipelined restoring divider: one quotient bit per stage, signed result truncated toward zero.
module rmq_div #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 18,
  parameter int unsigned TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num_mag,
  input  logic             num_neg,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [NUM_W-1:0] quot_mag,
  output logic             quot_neg,
  output logic [TAG_W-1:0] out_tag
);
  localparam int unsigned REM_W = DEN_W + 1;

  logic             vld [NUM_W+1];
  logic [NUM_W-1:0] qr  [NUM_W+1];
  logic [REM_W-1:0] rm  [NUM_W+1];
  logic [DEN_W-1:0] dn  [NUM_W+1];
  logic             ng  [NUM_W+1];
  logic [TAG_W-1:0] tg  [NUM_W+1];

  assign vld[0] = in_valid;
  assign qr[0]  = num_mag;
  assign rm[0]  = '0;
  assign dn[0]  = den;
  assign ng[0]  = num_neg;
  assign tg[0]  = in_tag;

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] diff;
    logic             fits;
    assign shifted = {rm[i][REM_W-2:0], qr[i][NUM_W-1]};
    assign fits    = shifted >= {1'b0, dn[i]};
    assign diff    = shifted - {1'b0, dn[i]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      qr[i+1] <= {qr[i][NUM_W-2:0], fits};
      rm[i+1] <= fits ? diff : shifted;
      dn[i+1] <= dn[i];
      ng[i+1] <= ng[i];
      tg[i+1] <= tg[i];
    end
  end

  assign out_valid = vld[NUM_W];
  assign quot_mag  = qr[NUM_W];
  assign quot_neg  = ng[NUM_W];
  assign out_tag   = tg[NUM_W];
endmodule

/* src/rmq_checker.sv */
// Port-level checks for the matrix to quaternion core, bound to the top level.
module rmq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              busy,
  input logic                              done,
  input logic signed [rmq_pkg::DATA_W-1:0] quat_w,
  input logic signed [rmq_pkg::DATA_W-1:0] quat_x,
  input logic signed [rmq_pkg::DATA_W-1:0] quat_y,
  input logic signed [rmq_pkg::DATA_W-1:0] quat_z,
  input logic                              degenerate
);
  import rmq_pkg::*;

  // fully pipelined: never refuses an item
  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy asserted");

  a_done_after_reset: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("done right after reset");

  a_degen_identity: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (quat_x == 0 && quat_y == 0 && quat_z == 0 && quat_w > 0))
    else $error("degenerate result is not identity");

  a_done_known: assert property (@(posedge clk) disable iff (rst) !$isunknown(done))
    else $error("done unknown");

  a_result_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown({quat_w, quat_x, quat_y, quat_z, degenerate}))
    else $error("result ports unknown with done");
endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker (
  .clk(clk), .rst(rst), .busy(busy), .done(done),
  .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
  .degenerate(degenerate)
);
